>>> src/b32dec_pkg.sv
// ----------------------------------------------------------------------------
// b32dec_pkg
// shared constants, types and the symbol lookup of the base32 secret decoder
// ----------------------------------------------------------------------------
package b32dec_pkg;

    localparam int SECRET_BYTES = 20;
    localparam int TEXT_BYTES   = 33;

    localparam int CNT_W  = 7;
    localparam int ACC_W  = 12;
    localparam int PEND_W = 4;
    localparam int SYM_W  = 5;

    localparam logic [CNT_W-1:0] TEXT_LAST  = CNT_W'(TEXT_BYTES - 1);
    localparam logic [CNT_W-1:0] SECRET_CNT = CNT_W'(SECRET_BYTES);
    localparam logic [CNT_W-1:0] POS_MAX    = {CNT_W{1'b1}};

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_Z   = 8'h5a;
    localparam logic [7:0] CHAR_2   = 8'h32;
    localparam logic [7:0] CHAR_7   = 8'h37;

    localparam logic [SYM_W-1:0]  DIGIT_BASE = SYM_W'(26);
    localparam logic [PEND_W-1:0] SYM_BITS   = PEND_W'(5);
    localparam logic [PEND_W-1:0] BYTE_BITS  = PEND_W'(8);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_slot;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       decode_ok;
        logic       last_result;
    } result_t;

    typedef struct packed {
        logic             bad;
        logic [SYM_W-1:0] value;
    } symbol_t;

    function automatic symbol_t symbol_lookup(input logic [7:0] ch);
        symbol_t s;
        logic [7:0] off_a;
        logic [7:0] off_2;
        off_a   = ch - CHAR_A;
        off_2   = ch - CHAR_2;
        s.bad   = 1'b1;
        s.value = '0;
        if (ch >= CHAR_A && ch <= CHAR_Z)
        begin
            s.bad   = 1'b0;
            s.value = off_a[SYM_W-1:0];
        end
        else if (ch >= CHAR_2 && ch <= CHAR_7)
        begin
            s.bad   = 1'b0;
            s.value = off_2[SYM_W-1:0] + DIGIT_BASE;
        end
        return s;
    endfunction

endpackage

>>> src/b32dec_in_stage.sv
// ----------------------------------------------------------------------------
// b32dec_in_stage
// input register: holds one text word until the decode stage takes it
// ----------------------------------------------------------------------------
module b32dec_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          text_byte,
    input  logic                final_slot,
    output logic                item_valid,
    output b32dec_pkg::item_t   item,
    input  logic                item_take
);

    logic              vld_reg;
    logic              vld_next;
    b32dec_pkg::item_t item_reg;

    assign in_ready   = !vld_reg || item_take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (item_take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.text_byte  <= text_byte;
            item_reg.final_slot <= final_slot;
        end
    end

endmodule

>>> src/b32dec_core.sv
// ----------------------------------------------------------------------------
// b32dec_core
// decode state, bit packing, final check and the result register
// ----------------------------------------------------------------------------
module b32dec_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  b32dec_pkg::item_t   item,
    output logic                item_take,
    output logic                res_valid,
    output b32dec_pkg::result_t res,
    input  logic                res_ready
);

    logic [b32dec_pkg::ACC_W-1:0]  acc_reg;
    logic [b32dec_pkg::ACC_W-1:0]  acc_next;
    logic [b32dec_pkg::PEND_W-1:0] pend_reg;
    logic [b32dec_pkg::PEND_W-1:0] pend_next;
    logic [b32dec_pkg::CNT_W-1:0]  syms_reg;
    logic [b32dec_pkg::CNT_W-1:0]  syms_next;
    logic [b32dec_pkg::CNT_W-1:0]  bytes_reg;
    logic [b32dec_pkg::CNT_W-1:0]  bytes_next;
    logic [b32dec_pkg::CNT_W-1:0]  pos_reg;
    logic [b32dec_pkg::CNT_W-1:0]  pos_next;
    logic                          stopped_reg;
    logic                          stopped_next;
    logic                          err_reg;
    logic                          err_next;
    logic                          res_vld_reg;
    logic                          res_vld_next;
    b32dec_pkg::result_t           res_reg;
    b32dec_pkg::result_t           res_next;

    b32dec_pkg::symbol_t           sym;
    logic [b32dec_pkg::ACC_W-1:0]  mask;
    logic [b32dec_pkg::ACC_W-1:0]  shifted;
    logic [b32dec_pkg::PEND_W-1:0] pend_add;
    logic                          produce;

    assign item_take = item_valid && (!res_vld_reg || res_ready);
    assign res_valid = res_vld_reg;
    assign res       = res_reg;
    assign sym       = b32dec_pkg::symbol_lookup(item.text_byte);
    assign mask      = (b32dec_pkg::ACC_W'(1) << pend_reg) - b32dec_pkg::ACC_W'(1);
    assign pend_add  = pend_reg + b32dec_pkg::SYM_BITS;

    always_comb
    begin
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        syms_next    = syms_reg;
        bytes_next   = bytes_reg;
        pos_next     = pos_reg;
        stopped_next = stopped_reg;
        err_next     = err_reg;
        produce      = 1'b0;
        res_next     = res_reg;
        shifted      = '0;
        if (item.final_slot)
        begin
            produce              = 1'b1;
            res_next.kind        = b32dec_pkg::KIND_STATUS;
            res_next.data_byte   = '0;
            res_next.last_result = 1'b1;
            res_next.decode_ok   = (item.text_byte == b32dec_pkg::CHAR_NUL) && !err_reg &&
                                   (syms_reg == b32dec_pkg::TEXT_LAST) &&
                                   (bytes_reg == b32dec_pkg::SECRET_CNT) &&
                                   ((acc_reg & mask) == '0);
            acc_next     = '0;
            pend_next    = '0;
            syms_next    = '0;
            bytes_next   = '0;
            pos_next     = '0;
            stopped_next = 1'b0;
            err_next     = 1'b0;
        end
        else
        begin
            if (pos_reg >= b32dec_pkg::TEXT_LAST)
            begin
                err_next = 1'b1;
            end
            if (pos_reg != b32dec_pkg::POS_MAX)
            begin
                pos_next = pos_reg + b32dec_pkg::CNT_W'(1);
            end
            if (!stopped_reg && !err_next)
            begin
                if (item.text_byte == b32dec_pkg::CHAR_NUL)
                begin
                    stopped_next = 1'b1;
                end
                else if (sym.bad)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    acc_next = {acc_reg[b32dec_pkg::ACC_W-b32dec_pkg::SYM_W-1:0], sym.value};
                    if (pend_add >= b32dec_pkg::BYTE_BITS)
                    begin
                        pend_next = pend_add - b32dec_pkg::BYTE_BITS;
                        if (bytes_reg >= b32dec_pkg::SECRET_CNT)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            shifted              = acc_next >> pend_next;
                            produce              = 1'b1;
                            res_next.kind        = b32dec_pkg::KIND_DATA;
                            res_next.data_byte   = shifted[7:0];
                            res_next.decode_ok   = 1'b0;
                            res_next.last_result = 1'b0;
                            bytes_next = bytes_reg + b32dec_pkg::CNT_W'(1);
                            syms_next  = syms_reg + b32dec_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        pend_next = pend_add;
                        syms_next = syms_reg + b32dec_pkg::CNT_W'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        res_vld_next = res_vld_reg && !res_ready;
        if (item_take && produce)
        begin
            res_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pend_reg    <= '0;
            syms_reg    <= '0;
            bytes_reg   <= '0;
            pos_reg     <= '0;
            stopped_reg <= 1'b0;
            err_reg     <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (item_take)
            begin
                acc_reg     <= acc_next;
                pend_reg    <= pend_next;
                syms_reg    <= syms_next;
                bytes_reg   <= bytes_next;
                pos_reg     <= pos_next;
                stopped_reg <= stopped_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && produce)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> src/base32_secret_decoder.sv
// ----------------------------------------------------------------------------
// base32_secret_decoder
// unpadded base32 text to secret bytes, with a final validity word
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | text_byte, final_slot
//  out     | out_valid/out_ready | kind, data_byte, decode_ok, last_result
//
//  one text word per cycle while results are taken; from accept to result a
//  word passes the input register and the result register, decode between them
//  a stalled result holds the decode stage, the input register still fills
//  reset clears all decode state; a final word also returns it to reset
// ----------------------------------------------------------------------------
module base32_secret_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       final_slot,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic       decode_ok,
    output logic       last_result
);

    logic                item_valid;
    logic                item_take;
    b32dec_pkg::item_t   item;
    b32dec_pkg::result_t res;

    b32dec_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .final_slot (final_slot),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    b32dec_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (out_valid),
        .res        (res),
        .res_ready  (out_ready)
    );

    assign kind        = res.kind;
    assign data_byte   = res.data_byte;
    assign decode_ok   = res.decode_ok;
    assign last_result = res.last_result;

endmodule

>>> tb/sv/base32_secret_decoder_test.sv
// ----------------------------------------------------------------------------
// base32_secret_decoder_test
// self-checking bench for the base32 secret decoder: a scoreboard predicts
// every data and status word from the accepted text words, random idling and
// stalls on both channels, one long receiver hold-off to fill the pipeline
// ----------------------------------------------------------------------------
module base32_secret_decoder_test;

    localparam int WORD_TARGET = 850;
    localparam int CALM_TAIL   = 120;
    localparam int HOLD_CYCLES = 300;

    typedef enum int
    {
        SHORT_TEXT,
        LONG_TEXT,
        BAD_SYMBOL,
        EARLY_NUL,
        BAD_TERMINATOR
    } text_flaw_t;

    localparam logic [8:0] OPENING_WORDS [0:25] = '{
        {1'b1, b32dec_pkg::CHAR_NUL},
        {1'b0, b32dec_pkg::CHAR_A}, {1'b0, b32dec_pkg::CHAR_7},
        {1'b0, b32dec_pkg::CHAR_Z}, {1'b0, b32dec_pkg::CHAR_2},
        {1'b1, b32dec_pkg::CHAR_NUL},
        {1'b0, "M"}, {1'b0, 8'hff}, {1'b0, "Q"}, {1'b1, b32dec_pkg::CHAR_NUL},
        {1'b0, "B"}, {1'b0, b32dec_pkg::CHAR_NUL}, {1'b0, "C"}, {1'b1, "D"},
        {1'b0, "H"}, {1'b0, "1"}, {1'b1, b32dec_pkg::CHAR_NUL},
        {1'b0, "Y"}, {1'b0, "8"}, {1'b1, b32dec_pkg::CHAR_NUL},
        {1'b0, "@"}, {1'b1, 8'hff},
        {1'b0, "["}, {1'b1, b32dec_pkg::CHAR_NUL},
        {1'b0, "a"}, {1'b1, b32dec_pkg::CHAR_NUL}
    };

    class decode_scoreboard;
        b32dec_pkg::result_t                awaited_results [$];
        int unsigned                        mismatches;
        logic [b32dec_pkg::ACC_W-1:0]       acc_bits;
        logic [b32dec_pkg::PEND_W-1:0]      held_bits;
        logic [b32dec_pkg::CNT_W-1:0]       symbol_count;
        logic [b32dec_pkg::CNT_W-1:0]       byte_count;
        logic [b32dec_pkg::CNT_W-1:0]       slot_index;
        bit                                 nul_seen;
        bit                                 text_broken;

        function new();
            mismatches = 0;
            clear_text();
        endfunction

        function void clear_text();
            acc_bits     = '0;
            held_bits    = '0;
            symbol_count = '0;
            byte_count   = '0;
            slot_index   = '0;
            nul_seen     = 1'b0;
            text_broken  = 1'b0;
        endfunction

        function void note_text_word(input logic [7:0] ch, input logic closing);
            b32dec_pkg::result_t          res;
            logic [b32dec_pkg::ACC_W-1:0] mask;
            logic [7:0]                   diff;
            logic [b32dec_pkg::SYM_W-1:0] sym;
            if (closing)
            begin
                mask = (b32dec_pkg::ACC_W'(1) << held_bits) - b32dec_pkg::ACC_W'(1);
                res.kind        = b32dec_pkg::KIND_STATUS;
                res.data_byte   = 8'h00;
                res.decode_ok   = ch == b32dec_pkg::CHAR_NUL && !text_broken
                                  && symbol_count == b32dec_pkg::TEXT_LAST
                                  && byte_count == b32dec_pkg::SECRET_CNT
                                  && (acc_bits & mask) == '0;
                res.last_result = 1'b1;
                awaited_results.push_back(res);
                clear_text();
                return;
            end
            if (slot_index >= b32dec_pkg::TEXT_LAST)
                text_broken = 1'b1;
            if (slot_index != b32dec_pkg::POS_MAX)
                slot_index++;
            if (nul_seen || text_broken)
                return;
            if (ch == b32dec_pkg::CHAR_NUL)
            begin
                nul_seen = 1'b1;
                return;
            end
            if (ch >= b32dec_pkg::CHAR_A && ch <= b32dec_pkg::CHAR_Z)
            begin
                diff = ch - b32dec_pkg::CHAR_A;
                sym  = diff[b32dec_pkg::SYM_W-1:0];
            end
            else if (ch >= b32dec_pkg::CHAR_2 && ch <= b32dec_pkg::CHAR_7)
            begin
                diff = ch - b32dec_pkg::CHAR_2 + 8'd26;
                sym  = diff[b32dec_pkg::SYM_W-1:0];
            end
            else
            begin
                text_broken = 1'b1;
                return;
            end
            acc_bits  = {acc_bits[b32dec_pkg::ACC_W-b32dec_pkg::SYM_W-1:0], sym};
            held_bits = held_bits + b32dec_pkg::SYM_BITS;
            if (held_bits >= b32dec_pkg::BYTE_BITS)
            begin
                held_bits = held_bits - b32dec_pkg::BYTE_BITS;
                if (byte_count >= b32dec_pkg::SECRET_CNT)
                begin
                    text_broken = 1'b1;
                    return;
                end
                res.kind        = b32dec_pkg::KIND_DATA;
                res.data_byte   = 8'(acc_bits >> held_bits);
                res.decode_ok   = 1'b0;
                res.last_result = 1'b0;
                awaited_results.push_back(res);
                byte_count++;
            end
            symbol_count++;
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_decoded_word(input b32dec_pkg::result_t got);
            b32dec_pkg::result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("decode_ok", want.decode_ok, got.decode_ok);
            compare_field("last_result", want.last_result, got.last_result);
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte   = 8'h00;
    logic       final_slot  = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic       kind;
    logic [7:0] data_byte;
    logic       decode_ok;
    logic       last_result;

    decode_scoreboard board = new();
    int unsigned      words_sent = 0;
    bit               idling = 1'b0;
    bit               hold_request = 1'b0;

    base32_secret_decoder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .final_slot  (final_slot),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .decode_ok   (decode_ok),
        .last_result (last_result)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_decoded_word({kind, data_byte, decode_ok, last_result});
    end

    function automatic logic [7:0] pick_symbol();
        int unsigned idx;
        idx = $urandom_range(0, 31);
        if (idx < 26)
            return b32dec_pkg::CHAR_A + 8'(idx);
        return b32dec_pkg::CHAR_2 + 8'(idx - 26);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic closing);
        in_valid   <= 1'b1;
        text_byte  <= b;
        final_slot <= closing;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_text_word(b, closing);
        words_sent++;
        if (idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.outstanding() != 0);
    endtask

    task automatic send_clean_text(input bit fixed, input logic [7:0] sym);
        int unsigned i;
        for (i = 0; i < b32dec_pkg::TEXT_LAST; i++)
            send_word(fixed ? sym : pick_symbol(), 1'b0);
        send_word(b32dec_pkg::CHAR_NUL, 1'b1);
    endtask

    task automatic send_flawed_text();
        text_flaw_t  flaw;
        int unsigned n;
        int unsigned i;
        int unsigned bad_at;
        int unsigned nul_at;
        logic [7:0]  b;
        logic [7:0]  closing;
        flaw    = text_flaw_t'($urandom_range(0, 4));
        n       = b32dec_pkg::TEXT_LAST;
        bad_at  = 1000;
        nul_at  = 1000;
        closing = b32dec_pkg::CHAR_NUL;
        case (flaw)
            SHORT_TEXT:     n = $urandom_range(0, b32dec_pkg::TEXT_LAST - 1);
            LONG_TEXT:      n = b32dec_pkg::TEXT_LAST + $urandom_range(1, 8);
            BAD_SYMBOL:     bad_at = $urandom_range(0, n - 1);
            EARLY_NUL:      nul_at = $urandom_range(0, n - 1);
            BAD_TERMINATOR: closing = 8'($urandom_range(0, 255));
            default:        n = b32dec_pkg::TEXT_LAST;
        endcase
        for (i = 0; i < n; i++)
        begin
            if (i == bad_at || i > nul_at)
                b = 8'($urandom_range(0, 255));
            else if (i == nul_at)
                b = b32dec_pkg::CHAR_NUL;
            else
                b = pick_symbol();
            send_word(b, 1'b0);
        end
        send_word(closing, 1'b1);
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready    <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (idling && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned i;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idling = 1'b1;
        for (i = 0; i < 26; i++)
            send_word(OPENING_WORDS[i][7:0], OPENING_WORDS[i][8]);
        drain_results();

        // long receiver hold-off while words keep coming
        idling       = 1'b0;
        hold_request = 1'b1;
        send_clean_text(1'b1, b32dec_pkg::CHAR_A);
        drain_results();
        send_clean_text(1'b1, b32dec_pkg::CHAR_7);

        while (words_sent < WORD_TARGET)
        begin
            idling = (words_sent + CALM_TAIL < WORD_TARGET) && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 99) < 65)
                send_clean_text(1'b0, b32dec_pkg::CHAR_A);
            else
                send_flawed_text();
        end
        idling = 1'b0;
        drain_results();
        repeat (10) @(posedge clk);

        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> base32_secret_decoder.f
src/b32dec_pkg.sv
src/b32dec_in_stage.sv
src/b32dec_core.sv
src/base32_secret_decoder.sv
tb/sv/base32_secret_decoder_test.sv
